[hw/rtl/mpfd_pkg.sv]
`default_nettype none
package mpfd_pkg;
  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;
  localparam int BUFFER_BYTES_DEF   = 1024;

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_RECT  = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;
  localparam logic [2:0] OP_SPAN  = 3'd6;
  localparam logic [2:0] OP_READ  = 3'd7;

  // datapath command from the controller
  typedef struct packed {
    logic       load;      // capture the input beat
    logic       seg_init;  // set up walker for segment seg
    logic [1:0] seg;       // outline segment, also selects line kind
    logic       step;      // visit current point, advance
    logic       wr;        // write back the fetched byte
  } mpfd_cmd_t;

  typedef struct packed {
    logic seg_last;  // current point is the last of the walk
    logic seg_empty; // walk has no points
  } mpfd_sts_t;
endpackage
`default_nettype wire

[hw/rtl/mono_page_framebuffer_draw_unit.sv]
`default_nettype none
// Draws into a one-bit-per-pixel page framebuffer: pixel, lines, rectangles,
// filled rectangles, byte spans cleared to zero, clears and byte read. Each
// touched pixel is a read-modify-write on the single-port store: the byte is
// read on a step and then written back. After reset and after a clear-all
// command the store is swept to zero one byte a cycle, with input stalled.
// One result beat per command; read_byte is zero except for read commands.
// A new command is taken while the previous result waits; it stalls only
// at completion if that result is still held.
module mono_page_framebuffer_draw_unit #(
  parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF,
  parameter int BUFFER_BYTES   = mpfd_pkg::BUFFER_BYTES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [2:0]  in_op,
  input  wire [7:0]  in_x_start,
  input  wire [7:0]  in_y_start,
  input  wire [7:0]  in_x_end,
  input  wire [7:0]  in_y_end,
  input  wire [7:0]  in_line_length,
  input  wire        in_pixel_on,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_read_byte,
  output logic [2:0] out_done_op
);
  import mpfd_pkg::*;

  mpfd_cmd_t  cmd;
  mpfd_sts_t  sts;
  logic [2:0] op_q;
  logic [7:0] rd_byte;
  logic       clr_busy;
  logic [7:0] rb_r;
  logic [2:0] op_r;
  logic       out_stall_hold;
  logic       done_c;

  mpfd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .in_op, .op_q, .clr_busy, .sts, .cmd
  );

  mpfd_datapath #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dp (
    .clk, .rst_n, .in_op, .in_x_start, .in_y_start, .in_x_end, .in_y_end,
    .in_line_length, .in_pixel_on, .cmd, .sts, .op_q, .rd_byte, .clr_busy
  );

  // hold a waiting beat; the write of the done state loads the final value
  assign out_stall_hold = out_valid && out_stall;
  assign done_c = cmd.wr && !out_stall_hold;

  always_ff @(posedge clk) begin
    if (done_c) begin
      rb_r <= (op_q == OP_READ) ? rd_byte : 8'd0;
      op_r <= op_q;
    end
  end

  assign out_read_byte = rb_r;
  assign out_done_op   = op_r;
endmodule
`default_nettype wire

[hw/rtl/mpfd_datapath.sv]
`default_nettype none
module mpfd_datapath #(
  parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF,
  parameter int BUFFER_BYTES   = mpfd_pkg::BUFFER_BYTES_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [2:0]             in_op,
  input  wire [7:0]             in_x_start,
  input  wire [7:0]             in_y_start,
  input  wire [7:0]             in_x_end,
  input  wire [7:0]             in_y_end,
  input  wire [7:0]             in_line_length,
  input  wire                   in_pixel_on,
  input  wire mpfd_pkg::mpfd_cmd_t cmd,
  output mpfd_pkg::mpfd_sts_t   sts,
  output logic [2:0]            op_q,
  output logic [7:0]            rd_byte,
  output logic                  clr_busy
);
  import mpfd_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int EW = AW + 1;

  logic [7:0] mem [BUFFER_BYTES];

  logic [2:0] op_r;
  logic [7:0] xs_r, ys_r, xe_r, ye_r, len_r;
  logic       on_r;
  logic [7:0] cx_r, cy_r, i_r, j_r, ni_r, nj_r;
  logic [1:0] seg_r;
  logic       seg_empty_r;
  logic       pv_r;      // pending write valid
  logic [AW-1:0] pa_r;
  logic [7:0] pm_r;
  logic       pset_r;
  logic [7:0] rdata_r;
  logic [EW-1:0] clr_r;
  logic       clr_busy_r;

  // capture and walker setup
  logic [7:0] w_c, h_c;
  assign w_c = xe_r - xs_r + 8'd1;
  assign h_c = ye_r - ys_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      xs_r  <= in_x_start;
      ys_r  <= in_y_start;
      xe_r  <= in_x_end;
      ye_r  <= in_y_end;
      len_r <= in_line_length;
      on_r  <= in_pixel_on;
    end
    if (cmd.seg_init) begin
      seg_r <= cmd.seg;
      i_r   <= 8'd0;
      j_r   <= 8'd0;
      unique case (op_r)
        OP_HLINE: begin
          cx_r <= xs_r; cy_r <= ys_r; ni_r <= len_r; nj_r <= 8'd1;
          seg_empty_r <= (len_r == 8'd0);
        end
        OP_VLINE: begin
          cx_r <= xs_r; cy_r <= ys_r; ni_r <= 8'd1; nj_r <= len_r;
          seg_empty_r <= (len_r == 8'd0);
        end
        OP_RECT: begin
          cx_r <= cmd.seg == 2'd3 ? xe_r : xs_r;
          cy_r <= cmd.seg == 2'd1 ? ye_r : ys_r;
          ni_r <= cmd.seg[1] ? 8'd1 : w_c;
          nj_r <= cmd.seg[1] ? h_c : 8'd1;
          seg_empty_r <= cmd.seg[1] ? (h_c == 8'd0) : (w_c == 8'd0);
        end
        OP_FILL: begin
          cx_r <= xs_r; cy_r <= ys_r; ni_r <= w_c; nj_r <= 8'd0;
          seg_empty_r <= (w_c == 8'd0);
        end
        OP_SPAN: begin
          cx_r <= xs_r; cy_r <= ys_r; ni_r <= xe_r; nj_r <= 8'd0;
          seg_empty_r <= (xs_r >= xe_r);
        end
        default: begin
          cx_r <= xs_r; cy_r <= ys_r; ni_r <= 8'd1; nj_r <= 8'd1;
          seg_empty_r <= 1'b0;
        end
      endcase
    end else if (cmd.step) begin
      unique case (op_r)
        OP_FILL: begin
          if (j_r == nj_r + h_c) begin
            j_r <= 8'd0;
            i_r <= i_r + 8'd1;
          end else begin
            j_r <= j_r + 8'd1;
          end
        end
        OP_SPAN: cx_r <= cx_r + 8'd1;
        default: begin
          if (nj_r == 8'd1 && !(op_r == OP_RECT && seg_r[1])) i_r <= i_r + 8'd1;
          else j_r <= j_r + 8'd1;
        end
      endcase
    end
  end

  logic last_c;
  always_comb begin
    unique case (op_r)
      OP_FILL: last_c = (j_r == h_c) && (i_r == ni_r - 8'd1);
      OP_SPAN: last_c = (cx_r + 8'd1 == ni_r);
      OP_VLINE: last_c = (j_r == nj_r - 8'd1);
      OP_RECT: last_c = seg_r[1] ? (j_r == nj_r - 8'd1) : (i_r == ni_r - 8'd1);
      default: last_c = (i_r == ni_r - 8'd1);
    endcase
  end
  assign sts.seg_last  = last_c;
  assign sts.seg_empty = seg_empty_r;

  // point address and mask
  logic [7:0] px, py;
  logic [17:0] a_full;
  logic        a_ok;
  logic [7:0]  mask_c;
  logic        set_c;
  always_comb begin
    px = cx_r + i_r;
    py = cy_r + j_r;
    mask_c = 8'd0;
    set_c  = 1'b1;
    if (op_r == OP_SPAN) begin
      a_full = 18'(ys_r) * 18'(DISPLAY_WIDTH) + 18'(cx_r);
      a_ok   = a_full < 18'(BUFFER_BYTES);
      mask_c = 8'hFF;
      set_c  = 1'b0;
    end else if (op_r == OP_READ) begin
      a_full = 18'(ys_r) * 18'(DISPLAY_WIDTH) + 18'(xs_r);
      a_ok   = a_full < 18'(BUFFER_BYTES);
    end else begin
      a_full = 18'(px) + 18'(py >> 3) * 18'(DISPLAY_WIDTH);
      a_ok   = (9'(px) < 9'(DISPLAY_WIDTH)) && (9'(py) < 9'(DISPLAY_HEIGHT))
               && (a_full < 18'(BUFFER_BYTES));
      mask_c = 8'd1 << py[2:0];
      set_c  = (op_r == OP_PIXEL) ? on_r : 1'b1;
    end
  end

  // clear sweep, pending read-modify-write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
      pv_r       <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        mem[clr_r[AW-1:0]] <= 8'd0;
        if (clr_r == EW'(BUFFER_BYTES - 1)) clr_busy_r <= 1'b0;
        clr_r <= clr_r + EW'(1);
      end else if (cmd.load && in_op == OP_CLEAR) begin
        clr_r      <= '0;
        clr_busy_r <= 1'b1;
      end else if (cmd.wr && pv_r) begin
        mem[pa_r] <= pset_r ? (rdata_r | pm_r) : (rdata_r & ~pm_r);
      end
      if (cmd.step) begin
        pv_r   <= a_ok;
        pa_r   <= a_full[AW-1:0];
        pm_r   <= mask_c;
        pset_r <= set_c;
      end else if (cmd.wr) begin
        pv_r <= 1'b0;
      end
    end
    if (cmd.step) rdata_r <= mem[a_full[AW-1:0]];
  end

  assign op_q     = op_r;
  assign rd_byte  = pv_r ? rdata_r : 8'd0;
  assign clr_busy = clr_busy_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !cmd.step) else $error("write and step together");
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !cmd.step) else $error("step during clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.seg_init) else $error("load with init");
endmodule
`default_nettype wire

[hw/rtl/mpfd_ctrl.sv]
`default_nettype none
module mpfd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  wire [2:0]           in_op,
  input  wire [2:0]           op_q,
  input  wire                 clr_busy,
  input  wire mpfd_pkg::mpfd_sts_t sts,
  output mpfd_pkg::mpfd_cmd_t cmd
);
  import mpfd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       last_r, last_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  assign in_stall  = (st_r != S_IDLE) || clr_busy;
  assign acc       = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    st_nxt   = st_r;
    seg_nxt  = seg_r;
    last_nxt = last_r;
    ov_nxt   = ov_r && out_stall;
    cmd      = '0;
    cmd.seg  = seg_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load = 1'b1;
          seg_nxt  = 2'd0;
          st_nxt   = (in_op == OP_CLEAR) ? S_CLR : S_INIT;
        end
      end
      S_INIT: begin
        cmd.seg_init = 1'b1;
        st_nxt = S_STEP;
      end
      S_STEP: begin
        if (sts.seg_empty) begin
          st_nxt = S_NEXT;
        end else begin
          cmd.step = 1'b1;
          last_nxt = sts.seg_last;
          st_nxt   = S_WR;
        end
      end
      S_WR: begin
        if (op_q == OP_READ) begin
          st_nxt = S_DONE;
        end else begin
          cmd.wr = 1'b1;
          st_nxt = last_r ? S_NEXT : S_STEP;
        end
      end
      S_NEXT: begin
        if (op_q == OP_RECT && seg_r != 2'd3) begin
          seg_nxt = seg_r + 2'd1;
          st_nxt  = S_INIT;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_CLR: begin
        if (!clr_busy) st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          cmd.wr = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ov_r   <= 1'b0;
      seg_r  <= 2'd0;
      last_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      seg_r  <= seg_nxt;
      last_r <= last_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> st_r != S_IDLE) else $error("accepted beat left idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r) else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> st_r == S_STEP) else $error("stray step");
endmodule
`default_nettype wire

[tb/tb_mono_page_framebuffer_draw_unit.sv]
`default_nettype none
import mpfd_pkg::*;

class draw_scoreboard;
  localparam int DW = DISPLAY_WIDTH_DEF;
  localparam int DH = DISPLAY_HEIGHT_DEF;
  localparam int NB = BUFFER_BYTES_DEF;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [2:0] done_op;
  } draw_result_t;

  logic [7:0]   page_mem [NB];
  draw_result_t pending_results [$];
  int           mismatches;

  function new();
    foreach (page_mem[i]) page_mem[i] = '0;
    mismatches = 0;
  endfunction

  function void plot(logic [7:0] x, logic [7:0] y, bit on);
    int addr;
    if (x >= DW || y >= DH) return;
    addr = int'(x) + int'(y >> 3) * DW;
    if (addr >= NB) return;
    page_mem[addr][y[2:0]] = on;
  endfunction

  function void hrun(logic [7:0] x, logic [7:0] y, int len);
    for (int i = 0; i < len; i++) plot(x + 8'(i), y, 1'b1);
  endfunction

  function void vrun(logic [7:0] x, logic [7:0] y, int len);
    for (int i = 0; i < len; i++) plot(x, y + 8'(i), 1'b1);
  endfunction

  function void note_command(logic [2:0] op, logic [7:0] xs, logic [7:0] ys,
                             logic [7:0] xe, logic [7:0] ye, logic [7:0] len,
                             bit on);
    logic [7:0]   w, h;
    int           addr;
    draw_result_t r;
    w = xe - xs + 8'd1;
    h = ye - ys;
    r.read_byte = '0;
    r.done_op = op;
    case (op)
      OP_PIXEL: plot(xs, ys, on);
      OP_HLINE: hrun(xs, ys, len);
      OP_VLINE: vrun(xs, ys, len);
      OP_RECT: begin
        hrun(xs, ys, w);
        hrun(xs, ye, w);
        vrun(xs, ys, h);
        vrun(xe, ys, h);
      end
      OP_FILL: begin
        for (int i = 0; i < int'(w); i++)
          for (int j = 0; j <= int'(h); j++) plot(xs + 8'(i), ys + 8'(j), 1'b1);
      end
      OP_CLEAR: foreach (page_mem[i]) page_mem[i] = '0;
      OP_SPAN: begin
        for (int i = xs; i < xe; i++) begin
          addr = int'(ys) * DW + i;
          if (addr < NB) page_mem[addr] = '0;
        end
      end
      default: begin
        addr = int'(ys) * DW + int'(xs);
        if (addr < NB) r.read_byte = page_mem[addr];
      end
    endcase
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [7:0] rb, logic [2:0] op);
    draw_result_t e;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: read_byte %h done_op %0d", rb, op);
      return;
    end
    e = pending_results.pop_front();
    if (rb !== e.read_byte || op !== e.done_op) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected read_byte %h done_op %0d, got %h %0d",
                 e.read_byte, e.done_op, rb, op);
    end
  endfunction
endclass

module tb_mono_page_framebuffer_draw_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_op;
  logic [7:0] in_x_start, in_y_start, in_x_end, in_y_end, in_line_length;
  logic       in_pixel_on;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_byte;
  logic [2:0] out_done_op;

  draw_scoreboard board;
  bit             no_idle;
  bit             hold_off;
  bit             stim_done;

  mono_page_framebuffer_draw_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end), .in_line_length(in_line_length),
    .in_pixel_on(in_pixel_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_byte(out_read_byte), .out_done_op(out_done_op)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_mono_page_framebuffer_draw_unit NOT OK");
    $finish;
  end

  task automatic send_beat(logic [2:0] op, logic [7:0] xs, logic [7:0] ys,
                           logic [7:0] xe, logic [7:0] ye, logic [7:0] len, bit on);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end <= xe;
    in_y_end <= ye;
    in_line_length <= len;
    in_pixel_on <= on;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(op, xs, ys, xe, ye, len, on);
  endtask

  task automatic send_random();
    logic [2:0] op;
    logic [7:0] xs, ys, xe, ye, len;
    op = 3'($urandom_range(7));
    xs = 8'($urandom);
    ys = 8'($urandom);
    len = 8'($urandom);
    if ($urandom_range(3) != 0) begin
      xs = 8'($urandom_range(135));
      ys = 8'($urandom_range(71));
      len = 8'($urandom_range(20));
    end
    xe = xs + 8'($urandom_range(12));
    ye = ys + 8'($urandom_range(10));
    if ($urandom_range(9) == 0) begin
      xe = 8'($urandom);
      ye = 8'($urandom);
    end
    if (op == OP_SPAN || op == OP_READ) ys = 8'($urandom_range(9));
    if (op == OP_CLEAR && $urandom_range(3) != 0) op = OP_READ;
    if (op == OP_FILL && int'(xe - xs) > 16) xe = xs + 8'($urandom_range(16));
    if (op == OP_FILL && int'(ye - ys) > 16) ye = ys + 8'($urandom_range(16));
    send_beat(op, xs, ys, xe, ye, len, $urandom_range(1));
  endtask

  initial begin
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_PIXEL;
    in_x_start <= '0;
    in_y_start <= '0;
    in_x_end <= '0;
    in_y_end <= '0;
    in_line_length <= '0;
    in_pixel_on <= 1'b0;
    no_idle = 1'b0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_beat(OP_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 8'd0, 1'b1);
    send_beat(OP_PIXEL, 8'd128, 8'd10, 8'd0, 8'd0, 8'd0, 1'b1);
    send_beat(OP_PIXEL, 8'd5, 8'd64, 8'd0, 8'd0, 8'd0, 1'b1);
    send_beat(OP_PIXEL, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 1'b1);
    send_beat(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd127, 8'd7, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1);
    send_beat(OP_HLINE, 8'd250, 8'd3, 8'd0, 8'd0, 8'd255, 1'b0);
    send_beat(OP_VLINE, 8'd7, 8'd250, 8'd0, 8'd0, 8'd255, 1'b0);
    send_beat(OP_HLINE, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_RECT, 8'd120, 8'd60, 8'd3, 8'd2, 8'd0, 1'b0);
    send_beat(OP_RECT, 8'd10, 8'd10, 8'd9, 8'd10, 8'd0, 1'b0);
    send_beat(OP_FILL, 8'd124, 8'd60, 8'd131, 8'd68, 8'd0, 1'b0);
    send_beat(OP_FILL, 8'd20, 8'd20, 8'd20, 8'd20, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd0, 8'd8, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_SPAN, 8'd120, 8'd7, 8'd200, 8'd0, 8'd0, 1'b0);
    send_beat(OP_SPAN, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_SPAN, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd124, 8'd7, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_beat(OP_READ, 8'd20, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0);

    for (int n = 0; n < 750; n++) begin
      if (n == 200) hold_off = 1'b1;
      no_idle = (n >= 400 && n < 500);
      send_random();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int stall_left;
    out_stall <= 1'b1;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_read_byte, out_done_op);
  end

  initial begin
    wait (stim_done);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("tb_mono_page_framebuffer_draw_unit OK");
    end else begin
      $display("tb_mono_page_framebuffer_draw_unit NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
